FILE: hdl/three_axis_pid_quad_mixer_defines.svh
// assertion macros for the pid mixer checker
// expects clk and rst_n in the scope where a macro is used

`ifndef THREE_AXIS_PID_QUAD_MIXER_DEFINES_SVH
`define THREE_AXIS_PID_QUAD_MIXER_DEFINES_SVH

// same-cycle implication
`define TAPQM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TAPQM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tapqm_pkg.sv
// shared widths, constants and register codes for the pid mixer
// no dependencies

package tapqm_pkg;

    localparam int GAIN_FRAC_BITS = 8;

    localparam int GAIN_W  = 16;
    localparam int LIMIT_W = 20;
    localparam int THR_W   = 10;
    localparam int ANGLE_W = 15;
    localparam int STICK_W = 10;
    localparam int PULSE_W = 12;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    localparam int ERR_W   = 16;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int INTEG_W = LIMIT_W + 1;
    localparam int MUL_A_W = INTEG_W + 1;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W;
    localparam int PID_W   = 10;
    localparam int CORR_W  = 8;
    localparam int MIX_W   = PULSE_W + 1;

    // floor(91 m / 50) and floor(3 m / 25) by reciprocal multiply
    localparam int SP_RECIP   = 119276;
    localparam int SP_SHIFT   = 16;
    localparam int SP_Q_W     = 11;
    localparam int CORR_RECIP = 7865;
    localparam int CORR_SHIFT = 16;
    localparam int CORR_Q_W   = 7;

    localparam int STICK_CENTRE = 500;
    localparam int PID_LIMIT    = 500;
    localparam int IDLE_PULSE   = 1000;
    localparam int TRIM_FRONT   = 1190;
    localparam int TRIM_SECOND  = 1055;
    localparam int TRIM_THIRD   = 1050;
    localparam int TRIM_FOURTH  = 1168;
    localparam int PULSE_MIN    = 921;
    localparam int PULSE_MAX    = 2393;

    localparam logic [GAIN_W-1:0]  KP_YAW_RST  = 16'd1024;
    localparam logic [GAIN_W-1:0]  KP_TILT_RST = 16'd333;
    localparam logic [GAIN_W-1:0]  KD_TILT_RST = 16'd4608;
    localparam logic [LIMIT_W-1:0] LIMIT_RST   = 20'hFFFFF;
    localparam logic [THR_W-1:0]   THR_RST     = 10'd50;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KP_YAW   = 3'd0,
        REG_KP_TILT  = 3'd1,
        REG_KI_YAW   = 3'd2,
        REG_KI_TILT  = 3'd3,
        REG_KD_YAW   = 3'd4,
        REG_KD_TILT  = 3'd5,
        REG_INT_LIM  = 3'd6,
        REG_THR_TH   = 3'd7
    } cfg_reg_t;

endpackage

FILE: hdl/tapqm_if.sv
// valid/ready channels for frame requests and motor pulse results
// depends on tapqm_pkg

interface tapqm_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [tapqm_pkg::ANGLE_W-1:0]  pitch_angle;
    logic signed [tapqm_pkg::ANGLE_W-1:0]  roll_angle;
    logic signed [tapqm_pkg::ANGLE_W-1:0]  yaw_rate;
    logic        [tapqm_pkg::STICK_W-1:0]  stick_yaw;
    logic        [tapqm_pkg::STICK_W-1:0]  stick_pitch;
    logic        [tapqm_pkg::STICK_W-1:0]  stick_roll;
    logic        [tapqm_pkg::STICK_W-1:0]  throttle;

    modport source (
        output valid, pitch_angle, roll_angle, yaw_rate,
               stick_yaw, stick_pitch, stick_roll, throttle,
        input  ready
    );
    modport sink (
        input  valid, pitch_angle, roll_angle, yaw_rate,
               stick_yaw, stick_pitch, stick_roll, throttle,
        output ready
    );
endinterface

interface tapqm_out_if;
    logic                              valid;
    logic                              ready;
    logic [tapqm_pkg::PULSE_W-1:0]     motor_front_pulse;
    logic [tapqm_pkg::PULSE_W-1:0]     motor_second_pulse;
    logic [tapqm_pkg::PULSE_W-1:0]     motor_third_pulse;
    logic [tapqm_pkg::PULSE_W-1:0]     motor_fourth_pulse;

    modport source (
        output valid, motor_front_pulse, motor_second_pulse,
               motor_third_pulse, motor_fourth_pulse,
        input  ready
    );
    modport sink (
        input  valid, motor_front_pulse, motor_second_pulse,
               motor_third_pulse, motor_fourth_pulse,
        output ready
    );
endinterface

FILE: hdl/three_axis_pid_quad_mixer.sv
// three-axis pid attitude controller with x-shaped quad mixer
// depends on tapqm_pkg and the channels in tapqm_if
//
//   channel     dir  handshake        payload
//   frame_in    in   valid / ready    angles, yaw rate, sticks, throttle
//   motor_out   out  valid / ready    four esc pulse widths
//   cfg_*       in   cfg_we           register index and write data
//
// after the accept in idle, each axis in turn runs the sp, err, prop, intg,
// deriv, sum, scale and corr states on the one shared multiplier (set point, p,
// i, d, correction scale), then the mix state writes the result
// frame_in.ready is high only while the sequencer is idle
// a pending result is held in the output register; the mix step waits for it
// reset clears integrals, previous errors and valid flags; no clearing pass

module three_axis_pid_quad_mixer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tapqm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tapqm_pkg::CFG_DATA_W-1:0]    cfg_data,
    tapqm_in_if.sink                            frame_in,
    tapqm_out_if.source                         motor_out
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_SP    = 10'b0000000010,
        ST_ERR   = 10'b0000000100,
        ST_PROP  = 10'b0000001000,
        ST_INTG  = 10'b0000010000,
        ST_DERIV = 10'b0000100000,
        ST_SUM   = 10'b0001000000,
        ST_SCALE = 10'b0010000000,
        ST_CORR  = 10'b0100000000,
        ST_MIX   = 10'b1000000000
    } state_t;

    typedef enum logic [1:0] {
        AXIS_YAW   = 2'd0,
        AXIS_PITCH = 2'd1,
        AXIS_ROLL  = 2'd2
    } axis_t;

    localparam int ERR_W   = tapqm_pkg::ERR_W;
    localparam int DIFF_W  = tapqm_pkg::DIFF_W;
    localparam int INTEG_W = tapqm_pkg::INTEG_W;
    localparam int ACC_W   = tapqm_pkg::ACC_W;
    localparam int PROD_W  = tapqm_pkg::PROD_W;
    localparam int MUL_A_W = tapqm_pkg::MUL_A_W;
    localparam int MUL_B_W = tapqm_pkg::MUL_B_W;
    localparam int PID_W   = tapqm_pkg::PID_W;
    localparam int CORR_W  = tapqm_pkg::CORR_W;
    localparam int MIX_W   = tapqm_pkg::MIX_W;
    localparam int STICK_W = tapqm_pkg::STICK_W;
    localparam int GAIN_W  = tapqm_pkg::GAIN_W;
    localparam int SP_Q_W  = tapqm_pkg::SP_Q_W;
    localparam int CQ_W    = tapqm_pkg::CORR_Q_W;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS =
        ACC_W'((1 << tapqm_pkg::GAIN_FRAC_BITS) - 1);
    localparam logic signed [ACC_W-1:0] ACC_ZERO = '0;
    localparam logic signed [ACC_W-1:0] PID_HI   = ACC_W'(tapqm_pkg::PID_LIMIT);
    localparam logic signed [ACC_W-1:0] PID_LO   = ACC_W'(-tapqm_pkg::PID_LIMIT);
    localparam logic signed [MIX_W-1:0] TRIM_F   = MIX_W'(tapqm_pkg::TRIM_FRONT);
    localparam logic signed [MIX_W-1:0] TRIM_S   = MIX_W'(tapqm_pkg::TRIM_SECOND);
    localparam logic signed [MIX_W-1:0] TRIM_T   = MIX_W'(tapqm_pkg::TRIM_THIRD);
    localparam logic signed [MIX_W-1:0] TRIM_R   = MIX_W'(tapqm_pkg::TRIM_FOURTH);

    // configuration registers
    logic [GAIN_W-1:0]                kp_yaw_reg, kp_tilt_reg;
    logic [GAIN_W-1:0]                ki_yaw_reg, ki_tilt_reg;
    logic [GAIN_W-1:0]                kd_yaw_reg, kd_tilt_reg;
    logic [tapqm_pkg::LIMIT_W-1:0]    int_lim_reg;
    logic [tapqm_pkg::THR_W-1:0]      thr_th_reg;

    // captured request
    logic signed [tapqm_pkg::ANGLE_W-1:0] pitch_reg, roll_reg, yaw_rate_reg;
    logic [STICK_W-1:0]               stick_yaw_reg, stick_pitch_reg, stick_roll_reg;
    logic [STICK_W-1:0]               thr_reg;

    // sequencer and datapath
    state_t                           state_reg, state_next;
    axis_t                            axis_reg, axis_next;
    logic signed [PROD_W-1:0]         prod_reg, prod_next;
    logic signed [ACC_W-1:0]          acc_reg, acc_next;
    logic signed [ERR_W-1:0]          err_reg, err_next;
    logic signed [DIFF_W-1:0]         diff_reg, diff_next;
    logic                             sign_reg, sign_next;
    logic signed [INTEG_W-1:0]        integ_reg [3];
    logic signed [INTEG_W-1:0]        integ_next [3];
    logic signed [ERR_W-1:0]          prev_reg [3];
    logic signed [ERR_W-1:0]          prev_next [3];
    logic signed [CORR_W-1:0]         corr_reg [3];
    logic signed [CORR_W-1:0]         corr_next [3];

    logic                             out_valid_reg, out_valid_next;
    logic [tapqm_pkg::PULSE_W-1:0]    front_reg, front_next;
    logic [tapqm_pkg::PULSE_W-1:0]    second_reg, second_next;
    logic [tapqm_pkg::PULSE_W-1:0]    third_reg, third_next;
    logic [tapqm_pkg::PULSE_W-1:0]    fourth_reg, fourth_next;

    // per-axis selection
    logic signed [tapqm_pkg::ANGLE_W-1:0] meas_sel;
    logic [STICK_W-1:0]               stick_sel;
    logic [GAIN_W-1:0]                kp_sel, ki_sel, kd_sel;

    // shared multiplier
    logic signed [MUL_A_W-1:0]        mul_a;
    logic signed [MUL_B_W-1:0]        mul_b;
    logic signed [PROD_W-1:0]         mul_p;

    logic signed [STICK_W:0]          stick_off;
    logic [STICK_W-1:0]               stick_mag;
    logic [SP_Q_W-1:0]                sp_q;
    logic signed [SP_Q_W:0]           sp_val;
    logic signed [INTEG_W:0]          integ_sum, lim_pos, lim_neg, integ_sat;
    logic signed [ACC_W-1:0]          acc_round, acc_shift;
    logic signed [PID_W-1:0]          pid_val;
    logic [PID_W-1:0]                 pid_mag;
    logic [CQ_W-1:0]                  corr_q;
    logic signed [MIX_W-1:0]          thr_ext, cy, cp, cr;
    logic signed [MIX_W-1:0]          mix_f, mix_s, mix_t, mix_r;
    logic                             run_motors;
    logic                             load_out;

    assign frame_in.ready = (state_reg == ST_IDLE);

    assign motor_out.valid              = out_valid_reg;
    assign motor_out.motor_front_pulse  = front_reg;
    assign motor_out.motor_second_pulse = second_reg;
    assign motor_out.motor_third_pulse  = third_reg;
    assign motor_out.motor_fourth_pulse = fourth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_yaw_reg  <= tapqm_pkg::KP_YAW_RST;
            kp_tilt_reg <= tapqm_pkg::KP_TILT_RST;
            ki_yaw_reg  <= '0;
            ki_tilt_reg <= '0;
            kd_yaw_reg  <= '0;
            kd_tilt_reg <= tapqm_pkg::KD_TILT_RST;
            int_lim_reg <= tapqm_pkg::LIMIT_RST;
            thr_th_reg  <= tapqm_pkg::THR_RST;
        end
        else if (cfg_we)
        begin
            case (tapqm_pkg::cfg_reg_t'(cfg_index))
                tapqm_pkg::REG_KP_YAW:  kp_yaw_reg  <= cfg_data[GAIN_W-1:0];
                tapqm_pkg::REG_KP_TILT: kp_tilt_reg <= cfg_data[GAIN_W-1:0];
                tapqm_pkg::REG_KI_YAW:  ki_yaw_reg  <= cfg_data[GAIN_W-1:0];
                tapqm_pkg::REG_KI_TILT: ki_tilt_reg <= cfg_data[GAIN_W-1:0];
                tapqm_pkg::REG_KD_YAW:  kd_yaw_reg  <= cfg_data[GAIN_W-1:0];
                tapqm_pkg::REG_KD_TILT: kd_tilt_reg <= cfg_data[GAIN_W-1:0];
                tapqm_pkg::REG_INT_LIM: int_lim_reg <= cfg_data[tapqm_pkg::LIMIT_W-1:0];
                tapqm_pkg::REG_THR_TH:  thr_th_reg  <= cfg_data[tapqm_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_in.valid && frame_in.ready)
        begin
            pitch_reg       <= frame_in.pitch_angle;
            roll_reg        <= frame_in.roll_angle;
            yaw_rate_reg    <= frame_in.yaw_rate;
            stick_yaw_reg   <= frame_in.stick_yaw;
            stick_pitch_reg <= frame_in.stick_pitch;
            stick_roll_reg  <= frame_in.stick_roll;
            thr_reg         <= frame_in.throttle;
        end
    end

    always_comb
    begin
        case (axis_reg)
            AXIS_YAW:
            begin
                meas_sel  = yaw_rate_reg;
                stick_sel = stick_yaw_reg;
                kp_sel    = kp_yaw_reg;
                ki_sel    = ki_yaw_reg;
                kd_sel    = kd_yaw_reg;
            end
            AXIS_PITCH:
            begin
                meas_sel  = pitch_reg;
                stick_sel = stick_pitch_reg;
                kp_sel    = kp_tilt_reg;
                ki_sel    = ki_tilt_reg;
                kd_sel    = kd_tilt_reg;
            end
            default:
            begin
                meas_sel  = roll_reg;
                stick_sel = stick_roll_reg;
                kp_sel    = kp_tilt_reg;
                ki_sel    = ki_tilt_reg;
                kd_sel    = kd_tilt_reg;
            end
        endcase
    end

    // set point offset and magnitude
    assign stick_off = $signed({1'b0, stick_sel}) - (STICK_W+1)'(tapqm_pkg::STICK_CENTRE);
    assign stick_mag = stick_off[STICK_W] ? STICK_W'(-stick_off) : STICK_W'(stick_off);

    // set point from reciprocal product
    assign sp_q   = prod_reg[tapqm_pkg::SP_SHIFT +: SP_Q_W];
    assign sp_val = sign_reg ? -$signed({1'b0, sp_q}) : $signed({1'b0, sp_q});

    // saturated integral
    assign integ_sum = (INTEG_W+1)'(integ_reg[axis_reg]) + (INTEG_W+1)'(err_reg);
    assign lim_pos   = $signed({2'b00, int_lim_reg});
    assign lim_neg   = -lim_pos;
    assign integ_sat = (integ_sum > lim_pos) ? lim_pos :
                       (integ_sum < lim_neg) ? lim_neg : integ_sum;

    // pid sum truncated toward zero and clamped
    assign acc_round = acc_reg + (acc_reg[ACC_W-1] ? ROUND_BIAS : ACC_ZERO);
    assign acc_shift = acc_round >>> tapqm_pkg::GAIN_FRAC_BITS;
    assign pid_val   = (acc_shift > PID_HI) ? PID_W'(PID_HI) :
                       (acc_shift < PID_LO) ? PID_W'(PID_LO) : PID_W'(acc_shift);
    assign pid_mag   = pid_val[PID_W-1] ? PID_W'(-pid_val) : PID_W'(pid_val);
    assign corr_q    = prod_reg[tapqm_pkg::CORR_SHIFT +: CQ_W];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SP:
            begin
                mul_a = $signed(MUL_A_W'(stick_mag));
                mul_b = MUL_B_W'(tapqm_pkg::SP_RECIP);
            end
            ST_PROP:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = $signed(MUL_B_W'(kp_sel));
            end
            ST_INTG:
            begin
                mul_a = MUL_A_W'(integ_reg[axis_reg]);
                mul_b = $signed(MUL_B_W'(ki_sel));
            end
            ST_DERIV:
            begin
                mul_a = MUL_A_W'(diff_reg);
                mul_b = $signed(MUL_B_W'(kd_sel));
            end
            ST_SCALE:
            begin
                mul_a = $signed(MUL_A_W'(pid_mag));
                mul_b = MUL_B_W'(tapqm_pkg::CORR_RECIP);
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // x mixer
    assign thr_ext    = $signed({3'b000, thr_reg});
    assign cy         = MIX_W'(corr_reg[AXIS_YAW]);
    assign cp         = MIX_W'(corr_reg[AXIS_PITCH]);
    assign cr         = MIX_W'(corr_reg[AXIS_ROLL]);
    assign mix_f      = TRIM_F + thr_ext + cr + cp + cy;
    assign mix_s      = TRIM_S + thr_ext - cr + cp - cy;
    assign mix_t      = TRIM_T + thr_ext + cr - cp - cy;
    assign mix_r      = TRIM_R + thr_ext - cr - cp + cy;
    assign run_motors = (thr_reg > thr_th_reg);
    assign load_out   = (state_reg == ST_MIX) && (!out_valid_reg || motor_out.ready);

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        diff_next      = diff_reg;
        sign_next      = sign_reg;
        integ_next     = integ_reg;
        prev_next      = prev_reg;
        corr_next      = corr_reg;
        out_valid_next = out_valid_reg;
        front_next     = front_reg;
        second_next    = second_reg;
        third_next     = third_reg;
        fourth_next    = fourth_reg;

        if (out_valid_reg && motor_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (frame_in.valid)
                begin
                    axis_next  = AXIS_YAW;
                    state_next = ST_SP;
                end
            end
            ST_SP:
            begin
                prod_next  = mul_p;
                sign_next  = stick_off[STICK_W];
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                err_next   = ERR_W'(meas_sel) - ERR_W'(sp_val);
                state_next = ST_PROP;
            end
            ST_PROP:
            begin
                integ_next[axis_reg] = INTEG_W'(integ_sat);
                diff_next            = DIFF_W'(err_reg) - DIFF_W'(prev_reg[axis_reg]);
                prev_next[axis_reg]  = err_reg;
                prod_next            = mul_p;
                state_next           = ST_INTG;
            end
            ST_INTG:
            begin
                acc_next   = prod_reg;
                prod_next  = mul_p;
                state_next = ST_DERIV;
            end
            ST_DERIV:
            begin
                acc_next   = acc_reg + prod_reg;
                prod_next  = mul_p;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                acc_next   = acc_reg + prod_reg;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                prod_next  = mul_p;
                sign_next  = pid_val[PID_W-1];
                state_next = ST_CORR;
            end
            ST_CORR:
            begin
                corr_next[axis_reg] = sign_reg ? -$signed(CORR_W'(corr_q))
                                               : $signed(CORR_W'(corr_q));
                case (axis_reg)
                    AXIS_YAW:
                    begin
                        axis_next  = AXIS_PITCH;
                        state_next = ST_SP;
                    end
                    AXIS_PITCH:
                    begin
                        axis_next  = AXIS_ROLL;
                        state_next = ST_SP;
                    end
                    default:
                    begin
                        state_next = ST_MIX;
                    end
                endcase
            end
            ST_MIX:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    if (run_motors)
                    begin
                        front_next  = mix_f[tapqm_pkg::PULSE_W-1:0];
                        second_next = mix_s[tapqm_pkg::PULSE_W-1:0];
                        third_next  = mix_t[tapqm_pkg::PULSE_W-1:0];
                        fourth_next = mix_r[tapqm_pkg::PULSE_W-1:0];
                    end
                    else
                    begin
                        front_next  = tapqm_pkg::PULSE_W'(tapqm_pkg::IDLE_PULSE);
                        second_next = tapqm_pkg::PULSE_W'(tapqm_pkg::IDLE_PULSE);
                        third_next  = tapqm_pkg::PULSE_W'(tapqm_pkg::IDLE_PULSE);
                        fourth_next = tapqm_pkg::PULSE_W'(tapqm_pkg::IDLE_PULSE);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= AXIS_YAW;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                integ_reg[i] <= '0;
                prev_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            integ_reg     <= integ_next;
            prev_reg      <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        err_reg    <= err_next;
        diff_reg   <= diff_next;
        sign_reg   <= sign_next;
        corr_reg   <= corr_next;
        front_reg  <= front_next;
        second_reg <= second_next;
        third_reg  <= third_next;
        fourth_reg <= fourth_next;
    end

endmodule

FILE: hdl/tapqm_checker.sv
// port-level checks for the pid mixer, bound to the top level
// depends on tapqm_pkg and three_axis_pid_quad_mixer_defines.svh

`include "three_axis_pid_quad_mixer_defines.svh"

module tapqm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [tapqm_pkg::PULSE_W-1:0]    front,
    input logic [tapqm_pkg::PULSE_W-1:0]    fourth
);

    logic in_acc;
    logic front_ok;
    logic fourth_ok;

    assign in_acc    = in_valid && in_ready;
    assign front_ok  = (front >= tapqm_pkg::PULSE_W'(tapqm_pkg::PULSE_MIN)) &&
                       (front <= tapqm_pkg::PULSE_W'(tapqm_pkg::PULSE_MAX));
    assign fourth_ok = (fourth >= tapqm_pkg::PULSE_W'(tapqm_pkg::PULSE_MIN)) &&
                       (fourth <= tapqm_pkg::PULSE_W'(tapqm_pkg::PULSE_MAX));

    // busy once a request is taken
    `TAPQM_ASSERT_NXT(busy_after_request, in_acc, !in_ready, "ready high right after a request")
    // no result straight out of a fresh request
    `TAPQM_ASSERT_NXT(no_instant_result, in_acc && !out_valid, !out_valid, "result too early")
    // pending result is held
    `TAPQM_ASSERT_NXT(result_held, out_valid && !out_ready, out_valid, "result dropped")
    // front and fourth pulse range
    `TAPQM_ASSERT_IMP(pulse_range, out_valid, front_ok && fourth_ok, "pulse out of range")

endmodule

bind three_axis_pid_quad_mixer tapqm_checker u_tapqm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (frame_in.valid),
    .in_ready  (frame_in.ready),
    .out_valid (motor_out.valid),
    .out_ready (motor_out.ready),
    .front     (motor_out.motor_front_pulse),
    .fourth    (motor_out.motor_fourth_pulse)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps

// self-checking bench for the three-axis pid mixer: a directed frame table, then random
// frames over a series of gain, limit and threshold settings, each result checked
// against a frame predictor; depends on tapqm_pkg, tapqm_if and three_axis_pid_quad_mixer

module testbench;

    localparam int ANGLE_W          = tapqm_pkg::ANGLE_W;
    localparam int STICK_W          = tapqm_pkg::STICK_W;
    localparam int PULSE_W          = tapqm_pkg::PULSE_W;
    localparam int GAIN_W           = tapqm_pkg::GAIN_W;
    localparam int THR_W            = tapqm_pkg::THR_W;
    localparam int CFG_INDEX_W      = tapqm_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W       = tapqm_pkg::CFG_DATA_W;
    localparam int STICK_CENTRE     = tapqm_pkg::STICK_CENTRE;
    localparam int ANGLE_MAX        = (1 << (ANGLE_W - 1)) - 1;
    localparam int ANGLE_MIN        = -ANGLE_MAX - 1;
    localparam int STICK_TOP        = (1 << STICK_W) - 1;
    localparam int NUM_PHASES       = 9;
    localparam int FRAMES_PER_PHASE = 190;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int MAX_REPORTS      = 100;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] yaw_rate;
        logic [STICK_W-1:0]        stick_yaw;
        logic [STICK_W-1:0]        stick_pitch;
        logic [STICK_W-1:0]        stick_roll;
        logic [STICK_W-1:0]        throttle;
    } frame_t;

    typedef logic [0:3][PULSE_W-1:0]    pulse_set_t;
    typedef logic [0:7][CFG_DATA_W-1:0] reg_set_t;

    // directed row: measurements, sticks and throttle as plain numbers
    typedef struct {
        int         pitch;
        int         roll;
        int         yaw;
        int         s_yaw;
        int         s_pitch;
        int         s_roll;
        int         thr;
        logic       typed;
        pulse_set_t pulses;
    } frame_row_t;

    localparam pulse_set_t IDLE_SET = {4{PULSE_W'(tapqm_pkg::IDLE_PULSE)}};

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tapqm_in_if  frame_in();
    tapqm_out_if motor_out();

    three_axis_pid_quad_mixer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame_in  (frame_in),
        .motor_out (motor_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state, index 0 yaw, 1 pitch, 2 roll
    longint gain_p [3];
    longint gain_i [3];
    longint gain_d [3];
    longint integ [3];
    longint prev_err [3];
    longint int_limit;
    longint thr_level;

    pulse_set_t expected_pulses [$];
    frame_row_t frame_rows [15];
    reg_set_t   fixed_settings [6];
    string      motor_name [4] = '{"front", "second", "third", "fourth"};

    int fails = 0;
    int frames_sent = 0;
    int results_seen = 0;
    int idle_results = 0;
    int reg_writes = 0;
    int settings_used = 0;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit send_gaps = 1'b0;
    bit recv_stalls = 1'b0;

    function automatic int stick_set_point(logic [STICK_W-1:0] s);
        int offset;
        offset = int'(s);
        offset = offset - STICK_CENTRE;
        return (offset * 182) / 100;
    endfunction

    function automatic int axis_correction(int ax, int meas, int sp);
        longint err, sum, diff, acc;
        err = longint'(meas) - longint'(sp);
        sum = integ[ax] + err;
        if (sum > int_limit)
            sum = int_limit;
        if (sum < -int_limit)
            sum = -int_limit;
        integ[ax] = sum;
        diff = err - prev_err[ax];
        prev_err[ax] = err;
        acc = err * gain_p[ax] + sum * gain_i[ax] + diff * gain_d[ax];
        acc = acc / (longint'(1) << tapqm_pkg::GAIN_FRAC_BITS);
        if (acc > tapqm_pkg::PID_LIMIT)
            acc = longint'(tapqm_pkg::PID_LIMIT);
        if (acc < -tapqm_pkg::PID_LIMIT)
            acc = -longint'(tapqm_pkg::PID_LIMIT);
        return int'((acc * 12) / 100);
    endfunction

    function automatic pulse_set_t compute_pulses(frame_t f);
        int cy, cp, cr, thr;
        pulse_set_t p;
        cy = axis_correction(0, $signed(f.yaw_rate), stick_set_point(f.stick_yaw));
        cp = axis_correction(1, $signed(f.pitch_angle), stick_set_point(f.stick_pitch));
        cr = axis_correction(2, $signed(f.roll_angle), stick_set_point(f.stick_roll));
        thr = int'(f.throttle);
        if (thr > thr_level)
        begin
            p[0] = PULSE_W'(tapqm_pkg::TRIM_FRONT + thr + cr + cp + cy);
            p[1] = PULSE_W'(tapqm_pkg::TRIM_SECOND + thr - cr + cp - cy);
            p[2] = PULSE_W'(tapqm_pkg::TRIM_THIRD + thr + cr - cp - cy);
            p[3] = PULSE_W'(tapqm_pkg::TRIM_FOURTH + thr - cr - cp + cy);
        end
        else
            p = IDLE_SET;
        return p;
    endfunction

    function automatic frame_t row_frame(frame_row_t r);
        frame_t f;
        f.pitch_angle = ANGLE_W'(r.pitch);
        f.roll_angle = ANGLE_W'(r.roll);
        f.yaw_rate = ANGLE_W'(r.yaw);
        f.stick_yaw = STICK_W'(r.s_yaw);
        f.stick_pitch = STICK_W'(r.s_pitch);
        f.stick_roll = STICK_W'(r.s_roll);
        f.throttle = STICK_W'(r.thr);
        return f;
    endfunction

    function automatic int extreme_angle();
        int k;
        k = $urandom_range(0, 2);
        return (k == 0) ? ANGLE_MIN : (k == 1) ? ANGLE_MAX : 0;
    endfunction

    function automatic int extreme_stick();
        int k;
        k = $urandom_range(0, 3);
        return (k == 0) ? 0 : (k == 1) ? 1000 : (k == 2) ? STICK_TOP : STICK_CENTRE;
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        int kind, v, a;
        kind = $urandom_range(0, 9);
        if (kind < 6)
        begin
            // level flight: sticks near centre, measurements near the set point
            f.stick_yaw = STICK_W'(STICK_CENTRE - 100 + $urandom_range(0, 200));
            f.stick_pitch = STICK_W'(STICK_CENTRE - 100 + $urandom_range(0, 200));
            f.stick_roll = STICK_W'(STICK_CENTRE - 100 + $urandom_range(0, 200));
            v = $urandom_range(0, 600);
            f.yaw_rate = ANGLE_W'(stick_set_point(f.stick_yaw) + v - 300);
            v = $urandom_range(0, 600);
            f.pitch_angle = ANGLE_W'(stick_set_point(f.stick_pitch) + v - 300);
            v = $urandom_range(0, 600);
            f.roll_angle = ANGLE_W'(stick_set_point(f.stick_roll) + v - 300);
            f.throttle = STICK_W'($urandom_range(0, 1000));
        end
        else if (kind < 9)
        begin
            f.pitch_angle = ANGLE_W'($urandom);
            f.roll_angle = ANGLE_W'($urandom);
            f.yaw_rate = ANGLE_W'($urandom);
            f.stick_yaw = STICK_W'($urandom);
            f.stick_pitch = STICK_W'($urandom);
            f.stick_roll = STICK_W'($urandom);
            f.throttle = STICK_W'($urandom);
        end
        else
        begin
            f.pitch_angle = ANGLE_W'(extreme_angle());
            f.roll_angle = ANGLE_W'(extreme_angle());
            f.yaw_rate = ANGLE_W'(extreme_angle());
            f.stick_yaw = STICK_W'(extreme_stick());
            f.stick_pitch = STICK_W'(extreme_stick());
            f.stick_roll = STICK_W'(extreme_stick());
            f.throttle = STICK_W'(extreme_stick());
        end
        if ($urandom_range(0, 7) == 0)
        begin
            // throttle either side of the idle threshold
            v = $urandom_range(0, 2);
            a = int'(thr_level) + v - 1;
            if (a < 0)
                a = 0;
            if (a > STICK_TOP)
                a = STICK_TOP;
            f.throttle = STICK_W'(a);
        end
        return f;
    endfunction

    function automatic reg_set_t random_settings();
        reg_set_t s;
        int k;
        // the six gains lead the register list
        for (int i = 0; i < 6; i++)
        begin
            k = $urandom_range(0, 9);
            s[i] = (k == 0) ? CFG_DATA_W'(0) :
                   (k == 1) ? CFG_DATA_W'($urandom_range(0, 65535)) :
                              CFG_DATA_W'($urandom_range(0, 1024));
        end
        s[tapqm_pkg::REG_INT_LIM] = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                    : CFG_DATA_W'($urandom_range(0, 50000));
        s[tapqm_pkg::REG_THR_TH] = ($urandom_range(0, 9) == 0)
                                   ? CFG_DATA_W'($urandom_range(0, STICK_TOP))
                                   : CFG_DATA_W'($urandom_range(0, 150));
        return s;
    endfunction

    task automatic write_reg(tapqm_pkg::cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
        logic [CFG_DATA_W-1:0] data;
        // unused upper data bits carry noise
        data = CFG_DATA_W'($urandom);
        case (r)
            tapqm_pkg::REG_INT_LIM: data = v;
            tapqm_pkg::REG_THR_TH:  data[THR_W-1:0] = v[THR_W-1:0];
            default:                data[GAIN_W-1:0] = v[GAIN_W-1:0];
        endcase
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= data;
        @(posedge clk);
        case (r)
            tapqm_pkg::REG_KP_YAW:  gain_p[0] = longint'(data[GAIN_W-1:0]);
            tapqm_pkg::REG_KP_TILT:
            begin
                gain_p[1] = longint'(data[GAIN_W-1:0]);
                gain_p[2] = longint'(data[GAIN_W-1:0]);
            end
            tapqm_pkg::REG_KI_YAW:  gain_i[0] = longint'(data[GAIN_W-1:0]);
            tapqm_pkg::REG_KI_TILT:
            begin
                gain_i[1] = longint'(data[GAIN_W-1:0]);
                gain_i[2] = longint'(data[GAIN_W-1:0]);
            end
            tapqm_pkg::REG_KD_YAW:  gain_d[0] = longint'(data[GAIN_W-1:0]);
            tapqm_pkg::REG_KD_TILT:
            begin
                gain_d[1] = longint'(data[GAIN_W-1:0]);
                gain_d[2] = longint'(data[GAIN_W-1:0]);
            end
            tapqm_pkg::REG_INT_LIM: int_limit = longint'(data);
            tapqm_pkg::REG_THR_TH:  thr_level = longint'(data[THR_W-1:0]);
            default:                ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_settings(reg_set_t s);
        tapqm_pkg::cfg_reg_t r;
        r = r.first();
        repeat (r.num())
        begin
            write_reg(r, s[r]);
            r = r.next();
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_idle();
        frame_in.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_pulses.size() != 0 || !frame_in.ready);
    endtask

    task automatic send_frame(frame_t f, logic typed, pulse_set_t typed_pulses);
        pulse_set_t p;
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            frame_in.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        frame_in.valid <= 1'b1;
        frame_in.pitch_angle <= f.pitch_angle;
        frame_in.roll_angle <= f.roll_angle;
        frame_in.yaw_rate <= f.yaw_rate;
        frame_in.stick_yaw <= f.stick_yaw;
        frame_in.stick_pitch <= f.stick_pitch;
        frame_in.stick_roll <= f.stick_roll;
        frame_in.throttle <= f.throttle;
        do
            @(posedge clk);
        while (!frame_in.ready);
        p = compute_pulses(f);
        expected_pulses.push_back(typed ? typed_pulses : p);
        frames_sent++;
    endtask

    always @(posedge clk)
    begin
        pulse_set_t got, want;
        if (motor_out.valid && motor_out.ready)
        begin
            got = {motor_out.motor_front_pulse, motor_out.motor_second_pulse,
                   motor_out.motor_third_pulse, motor_out.motor_fourth_pulse};
            results_seen++;
            if (got == IDLE_SET)
                idle_results++;
            if (expected_pulses.size() == 0)
            begin
                fails++;
                if (fails <= MAX_REPORTS)
                    $display("%0t: result %0d %0d %0d %0d with no request outstanding",
                             $time, got[0], got[1], got[2], got[3]);
            end
            else
            begin
                want = expected_pulses.pop_front();
                for (int m = 0; m < 4; m++)
                    if (got[m] !== want[m])
                    begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                            $display("%0t: %s pulse expected %0d, got %0d",
                                     $time, motor_name[m], want[m], got[m]);
                    end
            end
        end
        if (!rst_n)
            motor_out.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            motor_out.ready <= 1'b0;
        end
        else if (recv_stalls && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            motor_out.ready <= 1'b0;
        end
        else
            motor_out.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((frame_in.valid && frame_in.ready) || (motor_out.valid && motor_out.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
            $display("three_axis_pid_quad_mixer: mismatch");
            $finish;
        end
    end

    initial
    begin
        gain_p = '{longint'(tapqm_pkg::KP_YAW_RST), longint'(tapqm_pkg::KP_TILT_RST),
                   longint'(tapqm_pkg::KP_TILT_RST)};
        gain_i = '{'0, '0, '0};
        gain_d = '{'0, longint'(tapqm_pkg::KD_TILT_RST), longint'(tapqm_pkg::KD_TILT_RST)};
        integ = '{'0, '0, '0};
        prev_err = '{'0, '0, '0};
        int_limit = longint'(tapqm_pkg::LIMIT_RST);
        thr_level = longint'(tapqm_pkg::THR_RST);

        frame_rows = '{
            '{0, 0, 0, 500, 500, 500, 0, 1'b1, IDLE_SET},
            '{ANGLE_MAX, ANGLE_MIN, ANGLE_MAX, 500, 500, 500, 50, 1'b1, IDLE_SET},
            '{0, 0, 0, 500, 500, 500, 51, 1'b0, '0},
            '{0, 0, 0, 500, 500, 500, 51, 1'b1,
              {12'd1241, 12'd1106, 12'd1101, 12'd1219}},
            '{0, 0, 0, 500, 500, 500, 1000, 1'b1,
              {12'd2190, 12'd2055, 12'd2050, 12'd2168}},
            '{0, 0, 0, 500, 500, 500, STICK_TOP, 1'b1,
              {12'd2213, 12'd2078, 12'd2073, 12'd2191}},
            '{0, 0, 0, 0, 0, 0, 600, 1'b0, '0},
            '{0, 0, 0, 1000, 1000, 1000, 600, 1'b0, '0},
            '{0, 0, 0, STICK_TOP, STICK_TOP, STICK_TOP, 600, 1'b0, '0},
            '{ANGLE_MIN, ANGLE_MIN, ANGLE_MIN, STICK_TOP, STICK_TOP, STICK_TOP, STICK_TOP,
              1'b0, '0},
            '{ANGLE_MAX, ANGLE_MAX, ANGLE_MAX, 0, 0, 0, STICK_TOP, 1'b0, '0},
            '{10, -10, 3, 501, 499, 502, 300, 1'b0, '0},
            '{1, 0, -1, 500, 500, 500, STICK_TOP, 1'b0, '0},
            '{ANGLE_MIN, ANGLE_MAX, ANGLE_MIN, STICK_TOP, 0, STICK_TOP, 0, 1'b1, IDLE_SET},
            '{0, 0, 0, 500, 500, 500, 700, 1'b0, '0}
        };

        // kp_yaw kp_tilt ki_yaw ki_tilt kd_yaw kd_tilt limit threshold
        fixed_settings = '{
            {20'd256, 20'd128, 20'd64, 20'd32, 20'd512, 20'd1024, 20'd2000, 20'd100},
            {20'd65535, 20'd65535, 20'd65535, 20'd65535, 20'd65535, 20'd65535,
             20'hFFFFF, 20'd0},
            {20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd1023},
            {20'd0, 20'd0, 20'd65535, 20'd65535, 20'd0, 20'd0, 20'd0, 20'd10},
            {20'd128, 20'd128, 20'd200, 20'd200, 20'd0, 20'd0, 20'd300, 20'd60},
            {20'd200, 20'd150, 20'd20, 20'd20, 20'd300, 20'd300, 20'd20000, 20'd80}
        };

        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= tapqm_pkg::REG_KP_YAW;
        cfg_data <= '0;
        frame_in.valid <= 1'b0;
        frame_in.pitch_angle <= '0;
        frame_in.roll_angle <= '0;
        frame_in.yaw_rate <= '0;
        frame_in.stick_yaw <= '0;
        frame_in.stick_pitch <= '0;
        frame_in.stick_roll <= '0;
        frame_in.throttle <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_gaps = 1'b1;
        recv_stalls = 1'b1;
        foreach (frame_rows[i])
            send_frame(row_frame(frame_rows[i]), frame_rows[i].typed, frame_rows[i].pulses);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                wait_idle();
                if (ph < 6)
                    apply_settings(fixed_settings[ph - 1]);
                else if (ph < NUM_PHASES - 1)
                    apply_settings(random_settings());
                else
                    apply_settings(fixed_settings[5]);
            end
            for (int n = 0; n < FRAMES_PER_PHASE; n++)
            begin
                if (n % 50 == 0)
                begin
                    send_gaps = (ph < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
                    recv_stalls = (ph < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
                end
                send_frame(random_frame(), 1'b0, '0);
            end
        end
        frame_in.valid <= 1'b0;

        while (expected_pulses.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d frames: directed extremes, then flight, noise and edge values",
                 frames_sent);
        $display("over %0d register settings (%0d writes), %0d results, %0d idle, %0d failures",
                 settings_used + 1, reg_writes, results_seen, idle_results, fails);
        if (fails == 0)
            $display("three_axis_pid_quad_mixer: match");
        else
            $display("three_axis_pid_quad_mixer: mismatch");
        $finish;
    end

endmodule

FILE: three_axis_pid_quad_mixer.f
+incdir+hdl
hdl/tapqm_pkg.sv
hdl/tapqm_if.sv
hdl/three_axis_pid_quad_mixer.sv
hdl/tapqm_checker.sv
dv/testbench.sv
